FILE: sv/triangle_patch_splitter_assert.svh
// Assertion macros shared by the triangle patch splitter RTL.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef TRIANGLE_PATCH_SPLITTER_ASSERT_SVH
`define TRIANGLE_PATCH_SPLITTER_ASSERT_SVH

// Check a consequence in the same cycle as its antecedent.
`define TPS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define TPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/tps_pkg.sv
// Package of the triangle patch splitter: field widths, constants and the
// command and status structs between controller and datapath. No dependencies.
`default_nettype none

package tps_pkg;

    localparam int IDX_W     = 32;
    localparam int CFG_W     = 7;
    localparam int OFS_STEP  = 3;
    localparam int LIM_MIN   = 4;
    localparam logic [CFG_W-1:0] LIM_RESET = 7'd32;

    typedef struct packed {
        logic accept;
        logic search;
        logic decide;
        logic emit_lead;
        logic emit_rst;
        logic ins_a;
        logic ins_b;
        logic ins_c;
        logic emit_end;
    } t_dp_cmd;

    typedef struct packed {
        logic search_done;
        logic restart;
        logic first;
        logic last;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

FILE: sv/tps_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: sv/tps_ctrl.sv
// Controller of the triangle patch splitter: sequences search, decision,
// result transfers and store insertion. Depends on tps_pkg.
`default_nettype none

module tps_ctrl
    import tps_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_valid,
    output logic         o_s_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_SEARCH    = 9'b000000010,
        S_DECIDE    = 9'b000000100,
        S_EMIT_LEAD = 9'b000001000,
        S_EMIT_RST  = 9'b000010000,
        S_INS_A     = 9'b000100000,
        S_INS_B     = 9'b001000000,
        S_INS_C     = 9'b010000000,
        S_EMIT_END  = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_SEARCH;
                end
            end
            S_SEARCH: begin
                o_cmd.search = 1'b1;
                if (i_sts.search_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = S_EMIT_LEAD;
            end
            S_EMIT_LEAD: begin
                if (!i_sts.first) begin
                    n_state = i_sts.restart ? S_EMIT_RST : S_INS_A;
                end else if (i_sts.out_free) begin
                    o_cmd.emit_lead = 1'b1;
                    n_state         = i_sts.restart ? S_EMIT_RST : S_INS_A;
                end
            end
            S_EMIT_RST: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_rst = 1'b1;
                    n_state        = S_INS_A;
                end
            end
            S_INS_A: begin
                o_cmd.ins_a = 1'b1;
                n_state     = S_INS_B;
            end
            S_INS_B: begin
                o_cmd.ins_b = 1'b1;
                n_state     = S_INS_C;
            end
            S_INS_C: begin
                o_cmd.ins_c = 1'b1;
                n_state     = i_sts.last ? S_EMIT_END : S_IDLE;
            end
            S_EMIT_END: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_end = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

FILE: sv/tps_dp.sv
// Datapath of the triangle patch splitter: vertex store, counters, offset,
// limit register and output register. Depends on tps_pkg, tps_ram and the macros.
`default_nettype none
`include "triangle_patch_splitter_assert.svh"

module tps_dp
    import tps_pkg::*;
#(
    parameter int MAX_PATCH_VERTS = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [CFG_W-1:0]   i_cfg_wdata,
    input  wire logic [IDX_W-1:0]   i_index_a,
    input  wire logic [IDX_W-1:0]   i_index_b,
    input  wire logic [IDX_W-1:0]   i_index_c,
    input  wire logic               i_last,
    input  wire t_dp_cmd            i_cmd,
    output t_dp_sts                 o_sts,
    output logic                    o_m_tvalid,
    input  wire logic               i_m_tready,
    output logic      [IDX_W-1:0]   o_m_offset,
    output logic                    o_m_is_end
);

    localparam int AW = $clog2(MAX_PATCH_VERTS);
    localparam int CW = $clog2(MAX_PATCH_VERTS + 1);
    localparam int KW = ((CW > CFG_W) ? CW : CFG_W) + 2;

    logic [CFG_W-1:0] r_limit_cfg;
    logic [IDX_W-1:0] r_a;
    logic [IDX_W-1:0] r_b;
    logic [IDX_W-1:0] r_c;
    logic             r_last;
    logic             r_hit_a;
    logic             r_hit_b;
    logic             r_hit_c;
    logic [CW-1:0]    r_idx;
    logic             r_rd_vld;
    logic [CW-1:0]    r_seen_cnt;
    logic [CW-1:0]    r_patch_cnt;
    logic [IDX_W-1:0] r_offset;
    logic             r_first;
    logic             r_restart;
    logic             r_out_vld;
    logic [IDX_W-1:0] r_out_offset;
    logic             r_out_end;

    logic [KW-1:0]    w_cfg_ext;
    logic [KW-1:0]    w_lim;
    logic [1:0]       w_unseen;
    logic             w_restart;
    logic             w_re;
    logic             w_we;
    logic [IDX_W-1:0] w_wdata;
    logic [IDX_W-1:0] w_rdata;
    logic             w_emit;
    logic             w_out_free;

    always_comb begin
        w_cfg_ext = KW'(r_limit_cfg);
        if (w_cfg_ext < KW'(LIM_MIN)) begin
            w_lim = KW'(LIM_MIN);
        end else if (w_cfg_ext > KW'(MAX_PATCH_VERTS)) begin
            w_lim = KW'(MAX_PATCH_VERTS);
        end else begin
            w_lim = w_cfg_ext;
        end
    end

    assign w_unseen  = {1'b0, ~r_hit_a} + {1'b0, ~r_hit_b} + {1'b0, ~r_hit_c};
    assign w_restart = ((KW'(r_patch_cnt) + KW'(OFS_STEP)) > w_lim)
                    || ((KW'(r_seen_cnt) + KW'(w_unseen)) >= w_lim);

    assign w_re = i_cmd.search && (r_idx != r_seen_cnt);

    always_comb begin
        w_we    = 1'b0;
        w_wdata = r_a;
        if (i_cmd.ins_a) begin
            w_we    = r_restart || !r_hit_a;
            w_wdata = r_a;
        end else if (i_cmd.ins_b) begin
            w_we    = !((r_hit_b && !r_restart) || (r_b == r_a));
            w_wdata = r_b;
        end else if (i_cmd.ins_c) begin
            w_we    = !((r_hit_c && !r_restart) || (r_c == r_a) || (r_c == r_b));
            w_wdata = r_c;
        end
    end

    tps_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_PATCH_VERTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_seen_cnt[AW-1:0]),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_emit     = i_cmd.emit_lead || i_cmd.emit_rst || i_cmd.emit_end;
    assign w_out_free = !r_out_vld || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_a    <= i_index_a;
            r_b    <= i_index_b;
            r_c    <= i_index_c;
            r_last <= i_last;
        end
        if (i_cmd.accept) begin
            r_hit_a <= 1'b0;
            r_hit_b <= 1'b0;
            r_hit_c <= 1'b0;
        end else if (r_rd_vld) begin
            if (w_rdata == r_a) r_hit_a <= 1'b1;
            if (w_rdata == r_b) r_hit_b <= 1'b1;
            if (w_rdata == r_c) r_hit_c <= 1'b1;
        end
        if (i_cmd.decide) begin
            r_restart <= w_restart;
        end
        if (i_cmd.emit_lead) begin
            r_out_offset <= '0;
            r_out_end    <= 1'b0;
        end else if (i_cmd.emit_rst) begin
            r_out_offset <= r_offset;
            r_out_end    <= 1'b0;
        end else if (i_cmd.emit_end) begin
            r_out_offset <= r_offset;
            r_out_end    <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit_cfg <= LIM_RESET;
            r_idx       <= '0;
            r_rd_vld    <= 1'b0;
            r_seen_cnt  <= '0;
            r_patch_cnt <= '0;
            r_offset    <= '0;
            r_first     <= 1'b1;
            r_out_vld   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit_cfg <= i_cfg_wdata;
            end
            if (i_cmd.accept) begin
                r_idx <= '0;
            end else if (w_re) begin
                r_idx <= r_idx + CW'(1);
            end
            r_rd_vld <= w_re;
            if (i_cmd.decide && w_restart) begin
                r_seen_cnt  <= '0;
                r_patch_cnt <= '0;
            end else if (i_cmd.emit_end) begin
                r_seen_cnt  <= '0;
                r_patch_cnt <= '0;
            end else begin
                if (w_we) begin
                    r_seen_cnt <= r_seen_cnt + CW'(1);
                end
                if (i_cmd.ins_c) begin
                    r_patch_cnt <= r_patch_cnt + CW'(OFS_STEP);
                end
            end
            if (i_cmd.ins_c) begin
                r_offset <= r_offset + IDX_W'(OFS_STEP);
            end else if (i_cmd.emit_end) begin
                r_offset <= '0;
            end
            if (i_cmd.emit_lead) begin
                r_first <= 1'b0;
            end else if (i_cmd.emit_end) begin
                r_first <= 1'b1;
            end
            if (w_emit) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_sts.search_done = (r_idx == r_seen_cnt) && !r_rd_vld;
    assign o_sts.restart     = r_restart;
    assign o_sts.first       = r_first;
    assign o_sts.last        = r_last;
    assign o_sts.out_free    = w_out_free;

    assign o_m_tvalid = r_out_vld;
    assign o_m_offset = r_out_offset;
    assign o_m_is_end = r_out_end;

    `TPS_ASSERT_SAME(a_store_room, w_we, r_seen_cnt < CW'(MAX_PATCH_VERTS), "store written past depth")
    `TPS_ASSERT_SAME(a_emit_free, w_emit, !r_out_vld || i_m_tready, "result loaded over a pending transfer")
    `TPS_ASSERT_SAME(a_no_first_restart, i_cmd.decide && r_first, !w_restart, "restart on first triangle")
    `TPS_ASSERT_NEXT(a_end_rearms, i_cmd.emit_end, r_first && (r_seen_cnt == '0) && (r_offset == '0), "run not cleared after end")

endmodule

`default_nettype wire

FILE: sv/triangle_patch_splitter.sv
// Top level of the triangle patch splitter: joins controller and datapath.
// Depends on tps_pkg, tps_ctrl, tps_dp (and tps_ram below it).
//
//   channel   direction  handshake                  payload
//   s_axis    in         tvalid/tready              tdata: index_a, index_b, index_c; tlast
//   m_axis    out        tvalid/tready              tdata: boundary_offset; tlast: is_end
//   cfg       in         we                         wdata: patch_vertex_limit
//
// Each triangle runs a linear search over the store's single read port, then the decision,
// any result transfers and the insert steps; no new triangle is taken until the last is through.
// Reset is synchronous, active low; the limit resets to 32, the store needs no clear.
// One output register holds a result; transfer states wait while it is stalled.
`default_nettype none

module triangle_patch_splitter
    import tps_pkg::*;
#(
    parameter int MAX_PATCH_VERTS = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata,
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  wire logic [3*IDX_W-1:0]   i_s_axis_tdata,  // index_a, index_b, index_c
    input  wire logic                 i_s_axis_tlast,  // last_triangle
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    output logic      [IDX_W-1:0]     o_m_axis_tdata,  // boundary_offset
    output logic                      o_m_axis_tlast   // is_end
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    tps_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd)
    );

    tps_dp #(
        .MAX_PATCH_VERTS (MAX_PATCH_VERTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_index_a   (i_s_axis_tdata[IDX_W-1:0]),
        .i_index_b   (i_s_axis_tdata[2*IDX_W-1:IDX_W]),
        .i_index_c   (i_s_axis_tdata[3*IDX_W-1:2*IDX_W]),
        .i_last      (i_s_axis_tlast),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_m_tvalid  (o_m_axis_tvalid),
        .i_m_tready  (i_m_axis_tready),
        .o_m_offset  (o_m_axis_tdata),
        .o_m_is_end  (o_m_axis_tlast)
    );

endmodule

`default_nettype wire

FILE: tb/triangle_patch_splitter_checker.sv
// Checker for the triangle patch splitter: watches the triangle, boundary and
// limit ports, predicts patch boundaries and compares them. Depends on tps_pkg.

module triangle_patch_splitter_checker
    import tps_pkg::*;
#(
    parameter int MAX_PATCH_VERTS = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [CFG_W-1:0]   i_cfg_wdata,
    input  wire logic               i_s_axis_tvalid,
    input  wire logic               i_s_axis_tready,
    input  wire logic [3*IDX_W-1:0] i_s_axis_tdata,  // index_a, index_b, index_c
    input  wire logic               i_s_axis_tlast,  // last_triangle
    input  wire logic               i_m_axis_tvalid,
    input  wire logic               i_m_axis_tready,
    input  wire logic [IDX_W-1:0]   i_m_axis_tdata,  // boundary_offset
    input  wire logic               i_m_axis_tlast,  // is_end
    output int                      o_fail_count,
    output int                      o_pending
);

    typedef struct packed {
        logic [IDX_W-1:0] offset;
        logic             is_end;
    } t_boundary;

    t_boundary        boundary_q[$];
    logic [IDX_W-1:0] patch_verts[MAX_PATCH_VERTS];
    int               distinct_cnt;
    logic [7:0]       patch_idx_cnt;
    logic [IDX_W-1:0] tri_offset;
    logic             lead_pending;
    logic [CFG_W-1:0] limit_reg;
    int               fails = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic bit in_patch(logic [IDX_W-1:0] v);
        for (int k = 0; k < distinct_cnt; k++) begin
            if (patch_verts[k] == v) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void add_vertex(logic [IDX_W-1:0] v);
        if (!in_patch(v) && distinct_cnt < MAX_PATCH_VERTS) begin
            patch_verts[distinct_cnt] = v;
            distinct_cnt++;
        end
    endfunction

    function automatic void clear_run();
        distinct_cnt  = 0;
        patch_idx_cnt = '0;
        tri_offset    = '0;
        lead_pending  = 1'b1;
    endfunction

    function automatic void expect_boundary(logic [IDX_W-1:0] ofs, logic end_flag);
        t_boundary item;
        item.offset = ofs;
        item.is_end = end_flag;
        boundary_q  = {boundary_q, item};
    endfunction

    function automatic void split_triangle(logic [3*IDX_W-1:0] corners, logic last);
        logic [IDX_W-1:0] vert[3];
        int               lim;
        int               unseen;
        int               n;
        bit               restart;
        vert[0] = corners[IDX_W-1:0];
        vert[1] = corners[2*IDX_W-1:IDX_W];
        vert[2] = corners[3*IDX_W-1:2*IDX_W];
        lim     = int'(limit_reg);
        unseen  = 0;
        n       = 0;
        if (lim < LIM_MIN) begin
            lim = LIM_MIN;
        end
        if (lim > MAX_PATCH_VERTS) begin
            lim = MAX_PATCH_VERTS;
        end
        if (lead_pending) begin
            expect_boundary('0, 1'b0);
            n++;
            lead_pending = 1'b0;
        end
        if (int'(patch_idx_cnt) + OFS_STEP > lim) begin
            restart = 1'b1;
        end else begin
            for (int k = 0; k < 3; k++) begin
                if (!in_patch(vert[k])) begin
                    unseen++;
                end
            end
            restart = (distinct_cnt + unseen >= lim);
        end
        if (restart) begin
            expect_boundary(tri_offset, 1'b0);
            n++;
            patch_idx_cnt = '0;
            distinct_cnt  = 0;
        end
        for (int k = 0; k < 3; k++) begin
            add_vertex(vert[k]);
        end
        patch_idx_cnt = patch_idx_cnt + 8'(OFS_STEP);
        tri_offset    = tri_offset + IDX_W'(OFS_STEP);
        if (last) begin
            if (n < 2) begin
                expect_boundary(tri_offset, 1'b1);
            end
            clear_run();
        end
    endfunction

    task automatic report_mismatch(string what, logic [IDX_W-1:0] want, logic [IDX_W-1:0] got);
        fails++;
        $display("%0t boundary check: %s: expected %h, got %h", $time, what, want, got);
    endtask

    always @(posedge i_clk) begin
        t_boundary want;
        if (!i_rst_n) begin
            clear_run();
            limit_reg = LIM_RESET;
            boundary_q.delete();
        end else begin
            if (i_cfg_we) begin
                limit_reg = i_cfg_wdata;
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                split_triangle(i_s_axis_tdata, i_s_axis_tlast);
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (boundary_q.size() == 0) begin
                    report_mismatch("transfer with nothing expected", '0, i_m_axis_tdata);
                end else begin
                    want = boundary_q.pop_front();
                    if (i_m_axis_tdata !== want.offset) begin
                        report_mismatch("boundary_offset", want.offset, i_m_axis_tdata);
                    end
                    if (i_m_axis_tlast !== want.is_end) begin
                        report_mismatch("is_end", IDX_W'(want.is_end), IDX_W'(i_m_axis_tlast));
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= boundary_q.size();
    end

endmodule

FILE: tb/triangle_patch_splitter_tb.sv
// Testbench top for the triangle patch splitter: drives triangles, limit
// writes and output stalls. Depends on tps_pkg, triangle_patch_splitter and its checker.

module triangle_patch_splitter_tb;
    import tps_pkg::*;

    localparam int MAX_VERTS       = 64;
    localparam int DRAIN_CYCLES    = MAX_VERTS + 40;
    localparam int QUIET_LIMIT     = 4000;
    localparam int RAND_PHASES     = 8;
    localparam int PHASE_TRIANGLES = 125;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [CFG_W-1:0]   cfg_wdata = '0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [3*IDX_W-1:0] s_tdata = '0;
    logic               s_tlast = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [IDX_W-1:0]   m_tdata;
    logic               m_tlast;
    int                 fail_count;
    int                 pending_results;
    bit                 idle_en = 1'b1;
    int                 sink_hold = 0;
    logic [IDX_W-1:0]   pool_base = '0;
    int                 pool_span = 16;

    triangle_patch_splitter #(
        .MAX_PATCH_VERTS(MAX_VERTS)
    ) i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    triangle_patch_splitter_checker #(
        .MAX_PATCH_VERTS(MAX_VERTS)
    ) i_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .i_m_axis_tlast  (m_tlast),
        .o_fail_count    (fail_count),
        .o_pending       (pending_results)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(12, 48);
    endfunction

    always @(posedge clk) begin
        if (sink_hold != 0) begin
            sink_hold <= sink_hold - 1;
        end else if (!idle_en || $urandom_range(0, 3) != 0) begin
            m_tready  <= 1'b1;
            sink_hold <= $urandom_range(0, 6);
        end else begin
            m_tready  <= 1'b0;
            sink_hold <= pick_idle();
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("triangle_patch_splitter test failed");
        $finish;
    end

    task automatic send_triangle(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b,
                                 logic [IDX_W-1:0] c, logic last);
        int gap;
        gap = idle_en ? pick_idle() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {c, b, a};
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
    endtask

    // hold off until every boundary has arrived and the block has gone quiet
    task automatic drain_block();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(logic [CFG_W-1:0] value);
        drain_block();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_random_triangle();
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        logic [IDX_W-1:0] c;
        int               pick;
        pick = $urandom_range(0, 99);
        a = pool_base + $urandom_range(0, pool_span);
        b = pool_base + $urandom_range(0, pool_span);
        c = pool_base + $urandom_range(0, pool_span);
        if (pick >= 75 && pick < 85) begin
            a = $urandom();
            b = $urandom();
            c = $urandom();
        end else if (pick >= 85 && pick < 95) begin
            b = a;
            if ($urandom_range(0, 1) != 0) begin
                c = a;
            end
        end else if (pick >= 95) begin
            a = '1;
            c = '0;
        end
        if ($urandom_range(0, 7) == 0) begin
            pool_base = pool_base + $urandom_range(1, 8);
        end
        send_triangle(a, b, c, $urandom_range(0, 39) == 0);
    endtask

    initial begin
        logic [CFG_W-1:0] lim_val;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_triangle('0, '0, '0, 1'b1);
        send_triangle('1, '0, 32'h8000_0000, 1'b0);
        send_triangle(32'hAAAA_AAAA, 32'h5555_5555, '1, 1'b0);
        send_triangle(32'd1, 32'd2, 32'd3, 1'b1);

        write_limit(7'd0);
        send_triangle(32'd5, 32'd5, 32'd5, 1'b0);
        send_triangle(32'd5, 32'd5, 32'd5, 1'b0);
        send_triangle(32'd6, 32'd7, 32'd8, 1'b1);

        write_limit(7'd6);
        send_triangle(32'd10, 32'd11, 32'd12, 1'b0);
        send_triangle(32'd13, 32'd14, 32'd15, 1'b0);
        send_triangle(32'd13, 32'd13, 32'd16, 1'b0);
        send_triangle(32'd20, 32'd20, 32'd21, 1'b1);

        write_limit(7'd3);
        send_triangle(32'd1, 32'd2, 32'd3, 1'b0);
        send_triangle(32'd1, 32'd2, 32'd3, 1'b1);

        write_limit(7'h7F);
        send_triangle(32'd0, 32'd1, 32'd2, 1'b0);
        send_triangle(32'd2, 32'd3, 32'd4, 1'b0);
        send_triangle(32'd4, 32'd5, '1, 1'b1);

        write_limit(7'd65);
        send_triangle(32'd7, 32'd8, 32'd9, 1'b0);
        send_triangle(32'd9, 32'd8, 32'd7, 1'b1);

        write_limit(7'd5);
        send_triangle(32'd9, 32'd9, 32'd9, 1'b0);
        send_triangle(32'd9, 32'd9, 32'd9, 1'b1);

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0:       lim_val = 7'd4;
                1:       lim_val = 7'd64;
                2:       lim_val = 7'd2;
                7:       lim_val = 7'($urandom_range(0, 127));
                default: lim_val = 7'($urandom_range(4, 64));
            endcase
            write_limit(lim_val);
            idle_en   = (ph % 3 != 2);
            pool_base = $urandom();
            pool_span = $urandom_range(3, 100);
            repeat (PHASE_TRIANGLES) send_random_triangle();
        end

        drain_block();
        if (fail_count == 0) begin
            $display("triangle_patch_splitter test passed");
        end else begin
            $display("triangle_patch_splitter test failed");
        end
        $finish;
    end

endmodule

FILE: triangle_patch_splitter.f
+incdir+sv
sv/tps_pkg.sv
sv/tps_ram.sv
sv/tps_ctrl.sv
sv/tps_dp.sv
sv/triangle_patch_splitter.sv
tb/triangle_patch_splitter_checker.sv
tb/triangle_patch_splitter_tb.sv
